// ===== hdl/csblit_pkg.sv =====
package csblit_pkg;

    localparam int COORD_BITS = 16;
    localparam int ADDR_BITS  = 24;
    localparam int CNT_W      = 13;
    localparam int PIX_W      = 24;
    localparam int IDX_W      = 3;
    localparam int CFG_W      = (COORD_BITS > CNT_W) ? COORD_BITS : CNT_W;
    // world coordinates and viewport edges, one bit wider so nothing wraps
    localparam int WC_W       = CFG_W + 1;
    localparam int SUM_W      = 2 * CNT_W + 1;
    localparam int ADDR_KEEP  = (ADDR_BITS < PIX_W) ? ADDR_BITS : PIX_W;

    localparam logic [IDX_W-1:0] REG_VIEW_X   = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_VIEW_Y   = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_VIEW_W   = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_VIEW_H   = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_STRIDE   = IDX_W'(4);
    localparam logic [IDX_W-1:0] REG_SPRITE_W = IDX_W'(5);
    localparam logic [IDX_W-1:0] REG_SPRITE_H = IDX_W'(6);

    localparam logic [CNT_W-1:0] VIEW_W_RST   = CNT_W'(320);
    localparam logic [CNT_W-1:0] VIEW_H_RST   = CNT_W'(240);
    localparam logic [CNT_W-1:0] STRIDE_RST   = CNT_W'(320);
    localparam logic [CNT_W-1:0] SPRITE_W_RST = CNT_W'(16);
    localparam logic [CNT_W-1:0] SPRITE_H_RST = CNT_W'(16);

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] view_x;
        logic [COORD_BITS-1:0] view_y;
        logic [CNT_W-1:0]      view_w;
        logic [CNT_W-1:0]      view_h;
        logic [CNT_W-1:0]      stride;
        logic [CNT_W-1:0]      sprite_w;
        logic [CNT_W-1:0]      sprite_h;
    } t_cfg;

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic [PIX_W-1:0]      frame_pixel;
        logic [PIX_W-1:0]      mask_pixel;
    } t_req;

    // kept pixel, viewport-relative offsets
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] dx;
        logic [CNT_W-1:0] dy;
        logic [PIX_W-1:0] frame_pixel;
        logic [PIX_W-1:0] mask_pixel;
    } t_stage;

endpackage

// ===== hdl/csblit_in_if.sv =====
interface csblit_in_if;
    import csblit_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  req_type;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [PIX_W-1:0]      frame_pixel;
    logic [PIX_W-1:0]      mask_pixel;

    modport source (
        output valid, req_type, pos_x, pos_y, frame_pixel, mask_pixel,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_x, pos_y, frame_pixel, mask_pixel,
        output ready
    );
endinterface

// ===== hdl/csblit_out_if.sv =====
interface csblit_out_if;
    import csblit_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] write_address;
    logic [PIX_W-1:0] and_value;
    logic [PIX_W-1:0] or_value;

    modport source (
        output valid, write_address, and_value, or_value,
        input  ready
    );
    modport sink (
        input  valid, write_address, and_value, or_value,
        output ready
    );
endinterface

// ===== hdl/clipped_masked_sprite_blit.sv =====
// A kept pixel's write is registered in the clip stage, then in the output register.
// Throughput: one request per cycle unless both stages hold a write and the output is stalled;
// the clip stage can take a request, if it is empty, while the output register holds a write that has not been taken.
// Reset: synchronous, active low; sprite state, pipeline valids and config registers
// return to their reset values (viewport 320x240 at 0,0, stride 320, sprite 16x16).
module clipped_masked_sprite_blit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [csblit_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [csblit_pkg::CFG_W-1:0] i_cfg_data,
    csblit_in_if.sink                    i_req,
    csblit_out_if.source                 o_res
);
    import csblit_pkg::*;

    t_cfg   cfg;
    t_req   req;
    t_stage stage;
    logic   advance;
    logic   accept;

    // Stage 1 (clip): at accept, the row/column counters step and the world
    // coordinate is tested against the viewport; kept pixels are registered
    // with their viewport-relative offsets.
    // Stage 2 (address): one multiply-add forms the framebuffer index into
    // the output register.
    assign i_req.ready = !stage.valid || advance;
    assign accept      = i_req.valid && i_req.ready;

    assign req.req_type    = i_req.req_type;
    assign req.pos_x       = i_req.pos_x;
    assign req.pos_y       = i_req.pos_y;
    assign req.frame_pixel = i_req.frame_pixel;
    assign req.mask_pixel  = i_req.mask_pixel;

    csblit_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    csblit_clip u_clip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_accept  (accept),
        .i_req     (req),
        .i_advance (advance),
        .o_stage   (stage)
    );

    csblit_addr u_addr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_stage   (stage),
        .o_advance (advance),
        .o_res     (o_res)
    );

`ifndef SYNTHESIS
    // back-pressure only when both stages hold a write
    a_ready_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (stage.valid && o_res.valid))
        else $error("input stalled with a free stage");

    // a start request never produces a write
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.req_type == REQ_START) |=> !stage.valid)
        else $error("start request produced a write");

    // a pending write leaves only once taken
    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_res.valid) |-> $past(o_res.ready))
        else $error("write dropped before being taken");
`endif

endmodule

// ===== hdl/csblit_cfg.sv =====
module csblit_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [csblit_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [csblit_pkg::CFG_W-1:0] i_cfg_data,
    output csblit_pkg::t_cfg             o_cfg
);
    import csblit_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.view_x   <= '0;
            r_cfg.view_y   <= '0;
            r_cfg.view_w   <= VIEW_W_RST;
            r_cfg.view_h   <= VIEW_H_RST;
            r_cfg.stride   <= STRIDE_RST;
            r_cfg.sprite_w <= SPRITE_W_RST;
            r_cfg.sprite_h <= SPRITE_H_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_VIEW_X:   r_cfg.view_x   <= COORD_BITS'(i_cfg_data);
                REG_VIEW_Y:   r_cfg.view_y   <= COORD_BITS'(i_cfg_data);
                REG_VIEW_W:   r_cfg.view_w   <= CNT_W'(i_cfg_data);
                REG_VIEW_H:   r_cfg.view_h   <= CNT_W'(i_cfg_data);
                REG_STRIDE:   r_cfg.stride   <= CNT_W'(i_cfg_data);
                REG_SPRITE_W: r_cfg.sprite_w <= CNT_W'(i_cfg_data);
                REG_SPRITE_H: r_cfg.sprite_h <= CNT_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/csblit_clip.sv =====
module csblit_clip (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csblit_pkg::t_cfg   i_cfg,
    input  logic               i_accept,
    input  csblit_pkg::t_req   i_req,
    input  logic               i_advance,
    output csblit_pkg::t_stage o_stage
);
    import csblit_pkg::*;

    logic [COORD_BITS-1:0] r_origin_x, r_origin_y;
    logic [CNT_W-1:0]      r_col, r_row;
    logic                  r_active;
    t_stage                r_stage;

    logic [COORD_BITS-1:0] n_origin_x, n_origin_y;
    logic [CNT_W-1:0]      n_col, n_row;
    logic                  n_active;
    t_stage                n_stage;

    logic [WC_W-1:0]  wx, wy, vx_end, vy_end;
    logic [CNT_W-1:0] col_inc, row_inc;
    logic             sprite_done, in_view;

    always_comb begin
        wx     = WC_W'(r_origin_x) + WC_W'(r_col);
        wy     = WC_W'(r_origin_y) + WC_W'(r_row);
        vx_end = WC_W'(i_cfg.view_x) + WC_W'(i_cfg.view_w);
        vy_end = WC_W'(i_cfg.view_y) + WC_W'(i_cfg.view_h);
        in_view = (wx >= WC_W'(i_cfg.view_x)) && (wx < vx_end) &&
                  (wy >= WC_W'(i_cfg.view_y)) && (wy < vy_end);
        sprite_done = (i_cfg.sprite_w == '0) || (i_cfg.sprite_h == '0) ||
                      (r_row >= i_cfg.sprite_h);
        col_inc = r_col + CNT_W'(1);
        row_inc = r_row + CNT_W'(1);

        n_origin_x = r_origin_x;
        n_origin_y = r_origin_y;
        n_col      = r_col;
        n_row      = r_row;
        n_active   = r_active;

        n_stage.valid       = 1'b0;
        n_stage.dx          = CNT_W'(wx - WC_W'(i_cfg.view_x));
        n_stage.dy          = CNT_W'(wy - WC_W'(i_cfg.view_y));
        n_stage.frame_pixel = i_req.frame_pixel;
        n_stage.mask_pixel  = i_req.mask_pixel;

        if (i_req.req_type == REQ_START) begin
            n_origin_x = i_req.pos_x;
            n_origin_y = i_req.pos_y;
            n_col      = '0;
            n_row      = '0;
            n_active   = 1'b1;
        end else if (r_active) begin
            if (sprite_done) begin
                n_active = 1'b0;
            end else begin
                n_stage.valid = in_view;
                if (col_inc >= i_cfg.sprite_w) begin
                    n_col = '0;
                    n_row = row_inc;
                    if (row_inc >= i_cfg.sprite_h) begin
                        n_active = 1'b0;
                    end
                end else begin
                    n_col = col_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_active      <= 1'b0;
            r_stage.valid <= 1'b0;
        end else if (i_accept) begin
            r_origin_x <= n_origin_x;
            r_origin_y <= n_origin_y;
            r_col      <= n_col;
            r_row      <= n_row;
            r_active   <= n_active;
            r_stage    <= n_stage;
        end else if (i_advance) begin
            r_stage.valid <= 1'b0;
        end
    end

    assign o_stage = r_stage;

endmodule

// ===== hdl/csblit_addr.sv =====
module csblit_addr (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  csblit_pkg::t_cfg   i_cfg,
    input  csblit_pkg::t_stage i_stage,
    output logic               o_advance,
    csblit_out_if.source       o_res
);
    import csblit_pkg::*;

    localparam logic [PIX_W-1:0] ADDR_MASK = {PIX_W{1'b1}} >> (PIX_W - ADDR_KEEP);

    logic             r_valid;
    logic [PIX_W-1:0] r_addr, r_and, r_or;
    logic [SUM_W-1:0] n_sum;

    // row offset times stride plus column offset
    assign n_sum = SUM_W'(i_stage.dy) * SUM_W'(i_cfg.stride) + SUM_W'(i_stage.dx);

    assign o_advance = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_stage.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_stage.valid) begin
            r_addr <= PIX_W'(n_sum) & ADDR_MASK;
            r_and  <= i_stage.mask_pixel;
            r_or   <= i_stage.frame_pixel;
        end
    end

    assign o_res.valid         = r_valid;
    assign o_res.write_address = r_addr;
    assign o_res.and_value     = r_and;
    assign o_res.or_value      = r_or;

endmodule
